// ===== rtl/core/bnd_pkg.sv =====
// Shared types, constants and the symbol lookup for the base-N text decoder.
// No dependencies; imported by bnd_step and base_n_text_decoder.
package bnd_pkg;

  // Width of the internal byte counter (reported count saturates at 16 bits)
  localparam int COUNT_BITS = 16;
  localparam int REPORT_BITS = 16;

  // Alphabet selection
  typedef enum logic [1:0] {
    MODE_BASE16    = 2'd0,
    MODE_BASE32    = 2'd1,
    MODE_BASE32HEX = 2'd2,
    MODE_BASE64    = 2'd3
  } code_mode_t;

  // Character codes used by the lookup and the padding check
  localparam logic [7:0] CH_PAD   = 8'h3D; // '='
  localparam logic [7:0] CH_PLUS  = 8'h2B; // '+'
  localparam logic [7:0] CH_SLASH = 8'h2F; // '/'
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  // Stream state carried between characters
  typedef struct packed {
    logic [2:0]            group_position;
    logic [5:0]            symbol_before;
    logic [5:0]            symbol_two_before;
    logic                  padding_seen;
    logic [2:0]            data_residue;
    logic                  error_seen;
    logic [COUNT_BITS-1:0] bytes_done;
  } bnd_state_t;

  // One result item
  typedef struct packed {
    logic [7:0]             out_byte;
    logic                   byte_valid;
    logic                   done_res;
    logic                   status;
    logic [REPORT_BITS-1:0] byte_count;
  } bnd_result_t;

  // Symbol lookup: bit 6 set means the character is outside the alphabet
  function automatic logic [6:0] symbol_of(code_mode_t mode, logic [7:0] c);
    logic       up;
    logic       lo;
    logic       dig;
    logic [7:0] letter;
    logic [7:0] digit;
    logic [6:0] sym;
    up     = (c >= CH_UA) && (c <= CH_UZ);
    lo     = (c >= CH_LA) && (c <= CH_LZ);
    dig    = (c >= CH_0) && (c <= CH_9);
    letter = up ? (c - CH_UA) : (lo ? (c - CH_LA) : 8'd0);
    digit  = c - CH_0;
    sym    = 7'h40;
    unique case (mode)
      MODE_BASE16: begin
        if (dig) sym = {1'b0, digit[5:0]};
        else if ((up || lo) && letter < 8'd6) sym = {1'b0, letter[5:0] + 6'd10};
      end
      MODE_BASE32: begin
        // digits 0, 1 and 8 stand for the letters O, L and B
        if (up || lo) sym = {1'b0, letter[5:0]};
        else if (c >= CH_2 && c <= CH_7) sym = {1'b0, 6'(c - CH_2) + 6'd26};
        else if (c == CH_0) sym = 7'd14;
        else if (c == CH_1) sym = 7'd11;
        else if (c == CH_8) sym = 7'd1;
      end
      MODE_BASE32HEX: begin
        if (dig) sym = {1'b0, digit[5:0]};
        else if ((up || lo) && letter < 8'd22) sym = {1'b0, letter[5:0] + 6'd10};
      end
      MODE_BASE64: begin
        if (up) sym = {1'b0, letter[5:0]};
        else if (lo) sym = {1'b0, letter[5:0] + 6'd26};
        else if (dig) sym = {1'b0, digit[5:0] + 6'd52};
        else if (c == CH_PLUS) sym = 7'd62;
        else if (c == CH_SLASH) sym = 7'd63;
      end
      default: sym = 7'h40;
    endcase
    return sym;
  endfunction

  // Data characters left in the final group that form whole bytes
  function automatic logic residue_ok(code_mode_t mode, logic [2:0] r);
    logic ok;
    unique case (mode)
      MODE_BASE16: ok = (r == 3'd0);
      MODE_BASE64: ok = (r == 3'd0) || (r == 3'd2) || (r == 3'd3);
      default:     ok = (r == 3'd0) || (r == 3'd2) || (r == 3'd4) ||
                        (r == 3'd5) || (r == 3'd7);
    endcase
    return ok;
  endfunction

endpackage

// ===== rtl/core/bnd_step.sv =====
// One decode step: symbol lookup, byte assembly and next stream state.
// Depends on bnd_pkg (state/result types, symbol_of, residue_ok).
module bnd_step (
  input  bnd_pkg::code_mode_t  code_mode,
  input  logic [7:0]           text_char,
  input  logic                 last_char,
  input  bnd_pkg::bnd_state_t  state,
  output bnd_pkg::bnd_state_t  state_next,
  output bnd_pkg::bnd_result_t result,
  output logic                 has_result
);
  import bnd_pkg::*;

  logic [2:0]  mask;
  logic [2:0]  pos;
  logic [2:0]  pos_inc;
  logic [6:0]  sym;
  logic [5:0]  v;
  logic [5:0]  p1;
  logic [5:0]  p2;
  logic [7:0]  b;
  logic        have;
  logic        err;
  logic        err_fin;
  logic        pad;
  logic [2:0]  residue;
  logic [2:0]  r;
  logic [COUNT_BITS-1:0] count_max;

  assign count_max  = '1;

  // Group size follows the mode
  always_comb begin
    unique case (code_mode)
      MODE_BASE16: mask = 3'd1;
      MODE_BASE64: mask = 3'd3;
      default:     mask = 3'd7;
    endcase
  end

  assign pos     = state.group_position & mask;
  assign pos_inc = (pos + 3'd1) & mask;
  assign sym     = symbol_of(code_mode, text_char);
  assign v       = sym[5:0];
  assign p1      = state.symbol_before;
  assign p2      = state.symbol_two_before;

  // Byte assembly from the held symbols and the current one
  always_comb begin
    b    = 8'd0;
    have = 1'b0;
    unique case (code_mode)
      MODE_BASE16: begin
        if (pos == 3'd1) begin
          b    = {p1[3:0], v[3:0]};
          have = 1'b1;
        end
      end
      MODE_BASE64: begin
        unique case (pos[1:0])
          2'd1: begin b = {p1[5:0], v[5:4]}; have = 1'b1; end
          2'd2: begin b = {p1[3:0], v[5:2]}; have = 1'b1; end
          2'd3: begin b = {p1[1:0], v[5:0]}; have = 1'b1; end
          default: ;
        endcase
      end
      default: begin
        unique case (pos)
          3'd1: begin b = {p1[4:0], v[4:2]}; have = 1'b1; end
          3'd3: begin b = {p2[1:0], p1[4:0], v[4]}; have = 1'b1; end
          3'd4: begin b = {p1[3:0], v[4:1]}; have = 1'b1; end
          3'd6: begin b = {p2[0], p1[4:0], v[4:3]}; have = 1'b1; end
          3'd7: begin b = {p1[2:0], v[4:0]}; have = 1'b1; end
          default: ;
        endcase
      end
    endcase
  end

  // Next state: group position, padding, error, symbol history and byte count
  always_comb begin
    state_next                = state;
    state_next.group_position = pos_inc;
    err                       = state.error_seen;
    pad                       = state.padding_seen;
    residue                   = state.data_residue;
    if (text_char == CH_PAD && code_mode != MODE_BASE16) begin
      if (pos < 3'd2) begin
        err = 1'b1;
      end else if (!state.padding_seen) begin
        pad     = 1'b1;
        residue = pos;
      end
    end else if (sym[6] || state.padding_seen) begin
      err = 1'b1;
    end else begin
      state_next.symbol_two_before = p1;
      state_next.symbol_before     = v;
    end
    state_next.padding_seen = pad;
    state_next.data_residue = residue;
    state_next.error_seen   = err;
    if (!err && !(text_char == CH_PAD && code_mode != MODE_BASE16) && !sym[6] && have &&
        state.bytes_done != count_max) begin
      state_next.bytes_done = state.bytes_done + 1'b1;
    end
    // last character: report and clear the stream
    if (last_char) begin
      state_next = '0;
    end
  end

  // Final status on the last character
  assign r       = pad ? residue : pos_inc;
  assign err_fin = err || (pad && pos_inc != 3'd0) || !residue_ok(code_mode, r);

  logic byte_ok;
  logic [COUNT_BITS-1:0] count_now;
  logic [31:0] count_now_wide;
  assign byte_ok = have && !err && !(text_char == CH_PAD && code_mode != MODE_BASE16) &&
                   !sym[6];
  assign count_now = (byte_ok && state.bytes_done != count_max) ?
                     state.bytes_done + 1'b1 : state.bytes_done;
  assign count_now_wide = 32'(count_now);

  // Result item
  always_comb begin
    result     = '0;
    has_result = 1'b0;
    if (last_char) begin
      has_result        = 1'b1;
      result.done_res   = 1'b1;
      result.status     = err_fin;
      result.byte_valid = byte_ok && !err_fin;
      result.out_byte   = (byte_ok && !err_fin) ? b : 8'd0;
      if (!err_fin) begin
        result.byte_count = (count_now_wide > 32'hFFFF) ? '1 : REPORT_BITS'(count_now_wide);
      end
    end else if (byte_ok) begin
      has_result        = 1'b1;
      result.byte_valid = 1'b1;
      result.out_byte   = b;
    end
  end

endmodule

// ===== rtl/core/base_n_text_decoder.sv =====
// Top level of the streaming base16/base32/base32hex/base64 text decoder.
// Depends on bnd_pkg and bnd_step.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one character per transfer,
//   text_char with last_char marking the end of the string. Output channel
//   (out_valid/out_ready) carries a result when a byte completes, and always
//   on the last character, where done_res, status and byte_count give the
//   outcome. Characters that neither finish a byte nor end the string give
//   no result.
//   code_mode is written through cfg_write/cfg_data; the user must write it
//   only while the block is idle, which the block itself does not enforce.
//   A character is registered on transfer and its result is then loaded into
//   the output register, where out_valid rises. Throughput: one character per
//   cycle while the receiver takes results, set by the single step unit
//   between the input and output registers. A stalled receiver holds the
//   result in the output register; the input register still takes a character,
//   which moves on only when it gives no result or the output register frees up.
//   Reset clears the mode to base16 and all stream state.
module base_n_text_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] text_char,
  input  logic       last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       done_res,
  output logic       status,
  output logic [15:0] byte_count
);
  import bnd_pkg::*;

  code_mode_t  code_mode;
  logic        s1_valid;
  logic [7:0]  s1_char;
  logic        s1_last;
  bnd_state_t  state;
  bnd_state_t  state_next;
  bnd_result_t step_result;
  bnd_result_t res;
  logic        step_has;
  logic        out_free;
  logic        advance;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      code_mode <= MODE_BASE16;
    end else if (cfg_write) begin
      code_mode <= code_mode_t'(cfg_data);
    end
  end

  bnd_step u_step (
    .code_mode  (code_mode),
    .text_char  (s1_char),
    .last_char  (s1_last),
    .state      (state),
    .state_next (state_next),
    .result     (step_result),
    .has_result (step_has)
  );

  // Handshake: the held character moves on when its result has room or it gives no result
  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid && (out_free || !step_has);
  assign in_ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char <= text_char;
      s1_last <= last_char;
    end
  end

  // Stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && step_has;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_has) begin
      res <= step_result;
    end
  end

  assign out_byte   = res.out_byte;
  assign byte_valid = res.byte_valid;
  assign done_res   = res.done_res;
  assign status     = res.status;
  assign byte_count = res.byte_count;

endmodule
